// ----- rtl/afc_pkg.sv -----
// shared types and constants of the box versus frustum plane culling block
package afc_pkg;

  localparam int PLANE_COUNT = 4;
  localparam int FRAC_BITS   = 16;

  localparam int NORMAL_W    = 18;
  localparam int COORD_W     = 32;
  localparam int OFFSET_W    = 32;
  localparam int REQ_IDX_W   = 2;

  localparam int PLANE_IDX_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  // wide enough to hold the plane count itself next to a request index
  localparam int IDX_CMP_W   = 4;

  localparam int PROD_W      = COORD_W + NORMAL_W;
  localparam int DOT_W       = PROD_W + 2;
  localparam int LIM_W       = OFFSET_W + FRAC_BITS;
  localparam int CMP_W       = ((DOT_W > LIM_W) ? DOT_W : LIM_W) + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    KIND_LOAD,
    KIND_TEST
  } kind_e;

  typedef struct packed {
    kind_e                        kind;
    logic [PLANE_IDX_W-1:0]       idx;
    logic signed [NORMAL_W-1:0]   normal_x;
    logic signed [NORMAL_W-1:0]   normal_y;
    logic signed [NORMAL_W-1:0]   normal_z;
    logic signed [OFFSET_W-1:0]   offset;
    logic signed [COORD_W-1:0]    min_x;
    logic signed [COORD_W-1:0]    min_y;
    logic signed [COORD_W-1:0]    min_z;
    logic signed [COORD_W-1:0]    max_x;
    logic signed [COORD_W-1:0]    max_y;
    logic signed [COORD_W-1:0]    max_z;
  } item_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

// ----- rtl/afc_front.sv -----
// front end: takes requests, sorts loads from tests and queues them in order
module afc_front (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start,
  output logic                                      busy,
  input  logic                                      req_type_i,
  input  logic [afc_pkg::REQ_IDX_W-1:0]             plane_index_i,
  input  logic signed [afc_pkg::NORMAL_W-1:0]       normal_x_i,
  input  logic signed [afc_pkg::NORMAL_W-1:0]       normal_y_i,
  input  logic signed [afc_pkg::NORMAL_W-1:0]       normal_z_i,
  input  logic signed [afc_pkg::OFFSET_W-1:0]       plane_offset_i,
  input  logic signed [afc_pkg::COORD_W-1:0]        min_x_i,
  input  logic signed [afc_pkg::COORD_W-1:0]        min_y_i,
  input  logic signed [afc_pkg::COORD_W-1:0]        min_z_i,
  input  logic signed [afc_pkg::COORD_W-1:0]        max_x_i,
  input  logic signed [afc_pkg::COORD_W-1:0]        max_y_i,
  input  logic signed [afc_pkg::COORD_W-1:0]        max_z_i,
  output afc_pkg::head_t                            head_o,
  input  logic                                      pop_i
);

  afc_pkg::item_t                      q_mem [afc_pkg::QUEUE_DEPTH];
  logic [afc_pkg::QPTR_W-1:0]          wr_ptr_q, wr_ptr_d;
  logic [afc_pkg::QPTR_W-1:0]          rd_ptr_q, rd_ptr_d;
  logic [afc_pkg::QCNT_W-1:0]          count_q, count_d;
  logic [afc_pkg::IDX_CMP_W-1:0]       idx_ext;
  logic                                in_range;
  logic                                accept;
  logic                                push;
  afc_pkg::item_t                      item;

  assign busy     = (count_q == afc_pkg::QCNT_W'(afc_pkg::QUEUE_DEPTH));
  assign accept   = start && !busy;
  assign idx_ext  = afc_pkg::IDX_CMP_W'(plane_index_i);
  assign in_range = (idx_ext < afc_pkg::IDX_CMP_W'(afc_pkg::PLANE_COUNT));
  // loads to a plane that does not exist are dropped here
  assign push     = accept && (req_type_i || in_range);

  always_comb begin
    item.kind     = req_type_i ? afc_pkg::KIND_TEST : afc_pkg::KIND_LOAD;
    item.idx      = idx_ext[afc_pkg::PLANE_IDX_W-1:0];
    item.normal_x = normal_x_i;
    item.normal_y = normal_y_i;
    item.normal_z = normal_z_i;
    item.offset   = plane_offset_i;
    item.min_x    = min_x_i;
    item.min_y    = min_y_i;
    item.min_z    = min_z_i;
    item.max_x    = max_x_i;
    item.max_y    = max_y_i;
    item.max_z    = max_z_i;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == afc_pkg::QPTR_W'(afc_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == afc_pkg::QPTR_W'(afc_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= item;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = q_mem[rd_ptr_q];

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= afc_pkg::QCNT_W'(afc_pkg::QUEUE_DEPTH))
    else $error("queue holds more entries than it has");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("back end popped an empty queue");

endmodule

// ----- rtl/afc_back.sv -----
// back end: plane store, one plane per cycle through three multipliers, compare
module afc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  afc_pkg::head_t head_i,
  output logic           pop_o,
  output logic           valid_o,
  output logic           visible_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e                                   state_q;
  logic [afc_pkg::PLANE_IDX_W-1:0]          plane_q;

  logic signed [afc_pkg::NORMAL_W-1:0]      nx_q  [afc_pkg::PLANE_COUNT];
  logic signed [afc_pkg::NORMAL_W-1:0]      ny_q  [afc_pkg::PLANE_COUNT];
  logic signed [afc_pkg::NORMAL_W-1:0]      nz_q  [afc_pkg::PLANE_COUNT];
  logic signed [afc_pkg::OFFSET_W-1:0]      off_q [afc_pkg::PLANE_COUNT];

  logic signed [afc_pkg::COORD_W-1:0]       min_x_q, min_y_q, min_z_q;
  logic signed [afc_pkg::COORD_W-1:0]       max_x_q, max_y_q, max_z_q;

  logic signed [afc_pkg::NORMAL_W-1:0]      nx, ny, nz;
  logic signed [afc_pkg::COORD_W-1:0]       cx, cy, cz;
  logic signed [afc_pkg::PROD_W-1:0]        px_d, py_d, pz_d;
  logic signed [afc_pkg::PROD_W-1:0]        px_q, py_q, pz_q;
  logic signed [afc_pkg::OFFSET_W-1:0]      off_s1_q;
  logic                                     prod_valid_q, prod_first_q, prod_last_q;

  logic signed [afc_pkg::CMP_W-1:0]         dot, lim;
  logic                                     over;
  logic                                     culled_q, culled_d;
  logic                                     last_plane;
  logic                                     ready;
  logic                                     issue;

  assign last_plane = (plane_q == afc_pkg::PLANE_IDX_W'(afc_pkg::PLANE_COUNT - 1));
  assign issue      = (state_q == ST_RUN);
  // the next entry may leave the queue while the last plane is issued
  assign ready      = (state_q == ST_IDLE) || last_plane;
  assign pop_o      = head_i.valid && ready;

  // near corner: max coordinate where the normal points negative
  always_comb begin
    nx   = nx_q[plane_q];
    ny   = ny_q[plane_q];
    nz   = nz_q[plane_q];
    cx   = nx[afc_pkg::NORMAL_W-1] ? max_x_q : min_x_q;
    cy   = ny[afc_pkg::NORMAL_W-1] ? max_y_q : min_y_q;
    cz   = nz[afc_pkg::NORMAL_W-1] ? max_z_q : min_z_q;
    px_d = afc_pkg::PROD_W'(cx) * afc_pkg::PROD_W'(nx);
    py_d = afc_pkg::PROD_W'(cy) * afc_pkg::PROD_W'(ny);
    pz_d = afc_pkg::PROD_W'(cz) * afc_pkg::PROD_W'(nz);
  end

  always_comb begin
    dot      = afc_pkg::CMP_W'(px_q) + afc_pkg::CMP_W'(py_q) + afc_pkg::CMP_W'(pz_q);
    lim      = afc_pkg::CMP_W'(off_s1_q) <<< afc_pkg::FRAC_BITS;
    over     = (dot > lim);
    culled_d = prod_first_q ? over : (culled_q | over);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      plane_q      <= '0;
      prod_valid_q <= 1'b0;
      prod_first_q <= 1'b0;
      prod_last_q  <= 1'b0;
      culled_q     <= 1'b0;
      valid_o      <= 1'b0;
      visible_o    <= 1'b0;
    end else begin
      prod_valid_q <= issue;
      prod_first_q <= issue && (plane_q == '0);
      prod_last_q  <= issue && last_plane;
      if (prod_valid_q) begin
        culled_q <= culled_d;
      end
      valid_o <= prod_valid_q && prod_last_q;
      if (prod_valid_q && prod_last_q) begin
        visible_o <= !culled_d;
      end
      if (issue && !last_plane) begin
        plane_q <= plane_q + 1'b1;
      end else begin
        plane_q <= '0;
      end
      if (ready) begin
        state_q <= (pop_o && head_i.item.kind == afc_pkg::KIND_TEST) ? ST_RUN : ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    px_q     <= px_d;
    py_q     <= py_d;
    pz_q     <= pz_d;
    off_s1_q <= off_q[plane_q];
    if (pop_o && head_i.item.kind == afc_pkg::KIND_TEST) begin
      min_x_q <= head_i.item.min_x;
      min_y_q <= head_i.item.min_y;
      min_z_q <= head_i.item.min_z;
      max_x_q <= head_i.item.max_x;
      max_y_q <= head_i.item.max_y;
      max_z_q <= head_i.item.max_z;
    end
    if (pop_o && head_i.item.kind == afc_pkg::KIND_LOAD) begin
      nx_q[head_i.item.idx]  <= head_i.item.normal_x;
      ny_q[head_i.item.idx]  <= head_i.item.normal_y;
      nz_q[head_i.item.idx]  <= head_i.item.normal_z;
      off_q[head_i.item.idx] <= head_i.item.offset;
    end
  end

  a_prod_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_valid_q |-> $past(state_q == ST_RUN))
    else $error("products latched outside a running test");

  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && state_q == ST_RUN) |-> last_plane)
    else $error("queue popped before the last plane was issued");

  a_result_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(prod_valid_q && prod_last_q))
    else $error("result strobe without a finished plane sweep");

endmodule

// ----- rtl/aabb_frustum_culling.sv -----
// top level of the box versus frustum plane culling block
// Requests are taken when start is high and busy low and go through a two-entry
// queue to the back end. A load writes one plane; a load to a plane index at or
// beyond PLANE_COUNT is dropped. A test sweeps the planes, one plane per cycle
// through the three 32x18 multipliers, and its visible flag appears on valid_o
// for one cycle, registered after the products of the last plane are compared.
// The multipliers are shared by all planes; the next queue entry is taken while
// the last plane of a test is issued. Results cannot be held off, so sample them
// whenever valid_o is high; busy only reflects a full queue.
// Test only against planes that were loaded.
module aabb_frustum_culling (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start,
  output logic                                      busy,
  input  logic                                      req_type_i,
  input  logic [afc_pkg::REQ_IDX_W-1:0]             plane_index_i,
  input  logic signed [afc_pkg::NORMAL_W-1:0]       normal_x_i,
  input  logic signed [afc_pkg::NORMAL_W-1:0]       normal_y_i,
  input  logic signed [afc_pkg::NORMAL_W-1:0]       normal_z_i,
  input  logic signed [afc_pkg::OFFSET_W-1:0]       plane_offset_i,
  input  logic signed [afc_pkg::COORD_W-1:0]        min_x_i,
  input  logic signed [afc_pkg::COORD_W-1:0]        min_y_i,
  input  logic signed [afc_pkg::COORD_W-1:0]        min_z_i,
  input  logic signed [afc_pkg::COORD_W-1:0]        max_x_i,
  input  logic signed [afc_pkg::COORD_W-1:0]        max_y_i,
  input  logic signed [afc_pkg::COORD_W-1:0]        max_z_i,
  output logic                                      valid_o,
  output logic                                      visible_o
);

  afc_pkg::head_t head;
  logic           pop;

  afc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .plane_index_i  (plane_index_i),
    .normal_x_i     (normal_x_i),
    .normal_y_i     (normal_y_i),
    .normal_z_i     (normal_z_i),
    .plane_offset_i (plane_offset_i),
    .min_x_i        (min_x_i),
    .min_y_i        (min_y_i),
    .min_z_i        (min_z_i),
    .max_x_i        (max_x_i),
    .max_y_i        (max_y_i),
    .max_z_i        (max_z_i),
    .head_o         (head),
    .pop_i          (pop)
  );

  afc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .pop_o     (pop),
    .valid_o   (valid_o),
    .visible_o (visible_o)
  );

endmodule
